// ----- sv/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// brb_pkg: shared definitions for the byte ring buffer burst unit
// Field widths, operation and status codes, state encoding and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package brb_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int MODE_W   = 2;
   localparam int LEN_W    = 10;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 11;

   // ring size after reset, before clamping to the ring depth
   localparam int CSR_RESET = 1024;

   // default sizing of the unit
   localparam int RING_DEPTH_DEF     = 1024;
   localparam int MAX_READ_BURST_DEF = 64;

   // operation codes carried in the mode field
   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE = 2'd0,
      MODE_READ  = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_CLEAR = 2'd3
   } brb_mode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_INVALID = 2'd2
   } brb_status_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RESP,
      ST_READ
   } brb_state_type;

   // controller to datapath
   typedef struct packed {
      logic take_item;
      logic read_step;
      logic show_read;
   } brb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic has_result;
      logic starts_read;
      logic read_final;
   } brb_stat_type;

endpackage

// ----- sv/brb_req_if.sv -----
// ----------------------------------------------------------------------------
// brb_req_if: request channel
// Valid/ready channel carrying one request item per beat.
// ----------------------------------------------------------------------------
interface brb_req_if;

   logic                          valid;
   logic                          ready;
   logic [brb_pkg::MODE_W-1:0]    mode;
   logic [brb_pkg::BYTE_W-1:0]    data_in;
   logic [brb_pkg::LEN_W-1:0]     request_length;
   logic                          burst_last;

   modport source (
      output valid, mode, data_in, request_length, burst_last,
      input  ready
   );

   modport sink (
      input  valid, mode, data_in, request_length, burst_last,
      output ready
   );

endinterface

// ----- sv/brb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// brb_rsp_if: response channel
// Valid/ready channel carrying one result item per beat.
// ----------------------------------------------------------------------------
interface brb_rsp_if;

   logic                          valid;
   logic                          ready;
   logic [brb_pkg::BYTE_W-1:0]    data_out;
   logic [brb_pkg::STATUS_W-1:0]  status;
   logic [brb_pkg::LEN_W-1:0]     moved_count;
   logic [brb_pkg::LEN_W-1:0]     free_space;
   logic [brb_pkg::LEN_W-1:0]     used_space;
   logic                          result_last;

   modport source (
      output valid, data_out, status, moved_count, free_space, used_space,
             result_last,
      input  ready
   );

   modport sink (
      input  valid, data_out, status, moved_count, free_space, used_space,
             result_last,
      output ready
   );

endinterface

// ----- sv/byte_ring_buffer_burst_unit.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst_unit: byte ring buffer with burst writes
// Circular byte store keeping one slot empty. Write bursts commit whole or
// not at all; read requests return a capped run of bytes.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               beat
//  req_bus   in         valid/ready             one write byte or one command
//  rsp_bus   out        valid/ready             one result (byte or status)
//  csr_*     in         write enable, no wait   ring size, clears the ring
//
//  A write byte inside a burst is taken and gives no result.
//  Every other request is accepted and then gives its result beats; a read
//  holds the unit until its last byte beat is taken, paced by the one
//  registered read port of the byte store.
//  Requests are taken only while no result is pending; a stalled result
//  holds. Reset is synchronous and empties the ring; no clearing pass.
//
module byte_ring_buffer_burst_unit #(
   parameter int RING_DEPTH     = brb_pkg::RING_DEPTH_DEF,
   parameter int MAX_READ_BURST = brb_pkg::MAX_READ_BURST_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   brb_req_if.sink                    req_bus,
   brb_rsp_if.source                  rsp_bus,
   input  logic                       csr_write_enable,
   input  logic [brb_pkg::CSR_W-1:0]  csr_write_data
);

   brb_pkg::brb_cmd_type  cmd;
   brb_pkg::brb_stat_type stat;

   // sequencing
   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // ring store and arithmetic
   brb_dpath #(
      .RING_DEPTH     (RING_DEPTH),
      .MAX_READ_BURST (MAX_READ_BURST)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .mode             (req_bus.mode),
      .data_in          (req_bus.data_in),
      .request_length   (req_bus.request_length),
      .burst_last       (req_bus.burst_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .data_out         (rsp_bus.data_out),
      .status           (rsp_bus.status),
      .moved_count      (rsp_bus.moved_count),
      .free_space       (rsp_bus.free_space),
      .used_space       (rsp_bus.used_space),
      .result_last      (rsp_bus.result_last)
   );

endmodule

// ----- sv/brb_ctrl.sv -----
// ----------------------------------------------------------------------------
// brb_ctrl: sequencing controller
// Takes one request at a time. A write byte inside a burst presents nothing;
// any other gives one result beat, or a read burst of one byte per ready cycle.
// ----------------------------------------------------------------------------
module brb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  brb_pkg::brb_stat_type stat,
   output brb_pkg::brb_cmd_type  cmd
);

   brb_pkg::brb_state_type state_ff;
   brb_pkg::brb_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brb_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (stat.starts_read) begin
                  state_in = brb_pkg::ST_READ;
               end else if (stat.has_result) begin
                  state_in = brb_pkg::ST_RESP;
               end
            end
         end
         brb_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = brb_pkg::ST_IDLE;
            end
         end
         brb_pkg::ST_READ: begin
            if (rsp_ready && stat.read_final) begin
               state_in = brb_pkg::ST_IDLE;
            end
         end
         default: state_in = brb_pkg::ST_IDLE;
      endcase
   end

   // outputs, no request taken while in reset
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd.take_item = 1'b0;
      cmd.read_step = 1'b0;
      cmd.show_read = 1'b0;
      unique case (state_ff)
         brb_pkg::ST_IDLE: begin
            req_ready     = !reset;
            cmd.take_item = req_valid && !reset;
         end
         brb_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         brb_pkg::ST_READ: begin
            rsp_valid     = 1'b1;
            cmd.show_read = 1'b1;
            cmd.read_step = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- sv/brb_dpath.sv -----
// ----------------------------------------------------------------------------
// brb_dpath: ring buffer datapath
// Byte store, read/write positions, burst tracking, count arithmetic and
// the result registers.
// ----------------------------------------------------------------------------
module brb_dpath #(
   parameter int RING_DEPTH     = brb_pkg::RING_DEPTH_DEF,
   parameter int MAX_READ_BURST = brb_pkg::MAX_READ_BURST_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request payload
   input  logic [brb_pkg::MODE_W-1:0]    mode,
   input  logic [brb_pkg::BYTE_W-1:0]    data_in,
   input  logic [brb_pkg::LEN_W-1:0]     request_length,
   input  logic                          burst_last,
   // ring size register
   input  logic                          csr_write_enable,
   input  logic [brb_pkg::CSR_W-1:0]     csr_write_data,
   // control
   input  brb_pkg::brb_cmd_type          cmd,
   output brb_pkg::brb_stat_type         stat,
   // result payload
   output logic [brb_pkg::BYTE_W-1:0]    data_out,
   output logic [brb_pkg::STATUS_W-1:0]  status,
   output logic [brb_pkg::LEN_W-1:0]     moved_count,
   output logic [brb_pkg::LEN_W-1:0]     free_space,
   output logic [brb_pkg::LEN_W-1:0]     used_space,
   output logic                          result_last
);

   localparam int AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SW  = $clog2(RING_DEPTH + 1);
   localparam int LW  = brb_pkg::LEN_W;
   localparam int WW  = ((SW > LW) ? SW : LW) + 1;
   localparam int CW  = ((SW > brb_pkg::CSR_W) ? SW : brb_pkg::CSR_W) + 1;
   localparam int NW  = $clog2(MAX_READ_BURST + 1);
   localparam int RESET_SIZE =
      (RING_DEPTH < brb_pkg::CSR_RESET) ? RING_DEPTH : brb_pkg::CSR_RESET;

   // storage and state
   logic [brb_pkg::BYTE_W-1:0] ring_mem [RING_DEPTH];
   logic [brb_pkg::BYTE_W-1:0] rd_data_ff;

   logic [SW-1:0] ring_size_ff,      ring_size_in;
   logic [AW-1:0] rd_pos_ff,         rd_pos_in;
   logic [AW-1:0] wr_pos_ff,         wr_pos_in;
   logic [AW-1:0] burst_addr_ff,     burst_addr_in;
   logic [LW-1:0] burst_pos_ff,      burst_pos_in;
   logic [LW-1:0] burst_count_ff,    burst_count_in;
   logic          burst_active_ff,   burst_active_in;
   logic          burst_accepted_ff, burst_accepted_in;
   logic          burst_mismatch_ff, burst_mismatch_in;
   logic [NW-1:0] rd_left_ff,        rd_left_in;
   logic [AW-1:0] rd_addr_ff,        rd_addr_in;
   brb_pkg::brb_status_type status_ff, status_in;
   logic [LW-1:0] moved_ff,          moved_in;

   // combinational terms
   logic [SW-1:0] used_cnt;
   logic [SW-1:0] free_cnt;
   logic          wr_en;
   logic [LW-1:0] eff_count;
   logic [LW-1:0] eff_pos;
   logic          eff_accepted;
   logic          eff_mismatch;
   logic [AW-1:0] eff_addr;
   logic          in_range;
   logic [LW-1:0] new_pos;
   logic          new_mismatch;
   logic [WW-1:0] avail_len;
   logic [NW-1:0] rd_count;
   logic [WW-1:0] rd_pos_sum;
   logic [WW-1:0] wr_pos_sum;
   logic [CW-1:0] csr_ext;
   logic [SW-1:0] csr_clamped;

   // position plus one, wrapping at the ring size
   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] pos,
                                              input logic [SW-1:0] size);
      logic [SW-1:0] nxt;
      nxt = SW'(pos) + SW'(1);
      if (nxt == size) begin
         wrap_inc = '0;
      end else begin
         wrap_inc = AW'(nxt);
      end
   endfunction

   // occupancy: positions always lie inside the ring
   always_comb begin
      if (wr_pos_ff >= rd_pos_ff) begin
         used_cnt = SW'(wr_pos_ff) - SW'(rd_pos_ff);
      end else begin
         used_cnt = ring_size_ff - (SW'(rd_pos_ff) - SW'(wr_pos_ff));
      end
      free_cnt = ring_size_ff - SW'(1) - used_cnt;
   end

   // burst view for the current write beat
   always_comb begin
      if (burst_active_ff) begin
         eff_count    = burst_count_ff;
         eff_pos      = burst_pos_ff;
         eff_accepted = burst_accepted_ff;
         eff_mismatch = burst_mismatch_ff;
         eff_addr     = burst_addr_ff;
      end else begin
         eff_count    = request_length;
         eff_pos      = '0;
         eff_accepted = (request_length != '0) &&
                        (WW'(free_cnt) >= WW'(request_length));
         eff_mismatch = 1'b0;
         eff_addr     = wr_pos_ff;
      end
      in_range     = eff_pos < eff_count;
      new_pos      = in_range ? (eff_pos + LW'(1)) : eff_pos;
      new_mismatch = eff_mismatch || !in_range;
      wr_pos_sum   = WW'(wr_pos_ff) + WW'(eff_count);
      if (wr_pos_sum >= WW'(ring_size_ff)) begin
         wr_pos_sum = wr_pos_sum - WW'(ring_size_ff);
      end
   end

   // read burst length: min of stored bytes, request and burst cap
   always_comb begin
      if (WW'(used_cnt) < WW'(request_length)) begin
         avail_len = WW'(used_cnt);
      end else begin
         avail_len = WW'(request_length);
      end
      if (avail_len > WW'(MAX_READ_BURST)) begin
         rd_count = NW'(MAX_READ_BURST);
      end else begin
         rd_count = NW'(avail_len);
      end
      rd_pos_sum = WW'(rd_pos_ff) + WW'(rd_count);
      if (rd_pos_sum >= WW'(ring_size_ff)) begin
         rd_pos_sum = rd_pos_sum - WW'(ring_size_ff);
      end
   end

   // ring size clamp
   always_comb begin
      csr_ext = CW'(csr_write_data);
      if (csr_ext < CW'(2)) begin
         csr_clamped = SW'(2);
      end else if (csr_ext > CW'(RING_DEPTH)) begin
         csr_clamped = SW'(RING_DEPTH);
      end else begin
         csr_clamped = SW'(csr_ext);
      end
   end

   // next state of the ring
   always_comb begin
      ring_size_in      = ring_size_ff;
      rd_pos_in         = rd_pos_ff;
      wr_pos_in         = wr_pos_ff;
      burst_addr_in     = burst_addr_ff;
      burst_pos_in      = burst_pos_ff;
      burst_count_in    = burst_count_ff;
      burst_active_in   = burst_active_ff;
      burst_accepted_in = burst_accepted_ff;
      burst_mismatch_in = burst_mismatch_ff;
      rd_left_in        = rd_left_ff;
      rd_addr_in        = rd_addr_ff;
      status_in         = status_ff;
      moved_in          = moved_ff;
      wr_en             = 1'b0;

      if (cmd.take_item) begin
         unique case (mode)
            brb_pkg::MODE_WRITE: begin
               wr_en = eff_accepted && in_range;
               if (burst_last) begin
                  burst_active_in   = 1'b0;
                  burst_accepted_in = 1'b0;
                  burst_mismatch_in = 1'b0;
                  burst_pos_in      = '0;
                  burst_count_in    = '0;
                  moved_in          = '0;
                  if ((eff_count == '0) || new_mismatch || (new_pos != eff_count)) begin
                     status_in = brb_pkg::STATUS_INVALID;
                  end else if (!eff_accepted) begin
                     status_in = brb_pkg::STATUS_EMPTY;
                  end else begin
                     status_in = brb_pkg::STATUS_OK;
                     moved_in  = eff_count;
                     wr_pos_in = AW'(wr_pos_sum);
                  end
               end else begin
                  burst_active_in   = 1'b1;
                  burst_count_in    = eff_count;
                  burst_pos_in      = new_pos;
                  burst_accepted_in = eff_accepted;
                  burst_mismatch_in = new_mismatch;
                  burst_addr_in     = in_range ? wrap_inc(eff_addr, ring_size_ff)
                                               : eff_addr;
               end
            end
            brb_pkg::MODE_READ: begin
               moved_in = '0;
               if (request_length == '0) begin
                  status_in = brb_pkg::STATUS_INVALID;
               end else if (used_cnt == '0) begin
                  status_in = brb_pkg::STATUS_EMPTY;
               end else begin
                  status_in  = brb_pkg::STATUS_OK;
                  moved_in   = LW'(rd_count);
                  rd_left_in = rd_count;
                  rd_addr_in = rd_pos_ff;
                  rd_pos_in  = AW'(rd_pos_sum);
               end
            end
            brb_pkg::MODE_QUERY: begin
               status_in = brb_pkg::STATUS_OK;
               moved_in  = '0;
            end
            brb_pkg::MODE_CLEAR: begin
               status_in         = brb_pkg::STATUS_OK;
               moved_in          = '0;
               rd_pos_in         = '0;
               wr_pos_in         = '0;
               burst_active_in   = 1'b0;
               burst_accepted_in = 1'b0;
               burst_mismatch_in = 1'b0;
               burst_pos_in      = '0;
               burst_count_in    = '0;
            end
            default: begin
               status_in = brb_pkg::STATUS_INVALID;
            end
         endcase
      end

      // advance through the read burst one beat at a time
      if (cmd.read_step) begin
         rd_left_in = rd_left_ff - NW'(1);
         rd_addr_in = wrap_inc(rd_addr_ff, ring_size_ff);
      end

      // ring size write clears the ring
      if (csr_write_enable) begin
         ring_size_in      = csr_clamped;
         rd_pos_in         = '0;
         wr_pos_in         = '0;
         burst_active_in   = 1'b0;
         burst_accepted_in = 1'b0;
         burst_mismatch_in = 1'b0;
         burst_pos_in      = '0;
         burst_count_in    = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff      <= SW'(RESET_SIZE);
         rd_pos_ff         <= '0;
         wr_pos_ff         <= '0;
         burst_pos_ff      <= '0;
         burst_count_ff    <= '0;
         burst_active_ff   <= 1'b0;
         burst_accepted_ff <= 1'b0;
         burst_mismatch_ff <= 1'b0;
         rd_left_ff        <= '0;
      end else begin
         ring_size_ff      <= ring_size_in;
         rd_pos_ff         <= rd_pos_in;
         wr_pos_ff         <= wr_pos_in;
         burst_pos_ff      <= burst_pos_in;
         burst_count_ff    <= burst_count_in;
         burst_active_ff   <= burst_active_in;
         burst_accepted_ff <= burst_accepted_in;
         burst_mismatch_ff <= burst_mismatch_in;
         rd_left_ff        <= rd_left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      burst_addr_ff <= burst_addr_in;
      rd_addr_ff    <= rd_addr_in;
      status_ff     <= status_in;
      moved_ff      <= moved_in;
   end

   // byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[eff_addr] <= data_in;
      end
      rd_data_ff <= ring_mem[rd_addr_in];
   end

   // status to the controller
   assign stat.has_result  = (mode != brb_pkg::MODE_WRITE) || burst_last;
   assign stat.starts_read = (mode == brb_pkg::MODE_READ) &&
                             (request_length != '0) && (used_cnt != '0);
   assign stat.read_final  = (rd_left_ff == NW'(1));

   // result fields
   assign data_out    = cmd.show_read ? rd_data_ff : '0;
   assign status      = status_ff;
   assign moved_count = moved_ff;
   assign free_space  = LW'(WW'(free_cnt));
   assign used_space  = LW'(WW'(used_cnt));
   assign result_last = cmd.show_read ? (rd_left_ff == NW'(1)) : 1'b1;

endmodule
